// File: hw/rtl/hvac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvac_pkg
// Shared types, codes and reset values of the thermostat controller.
// ----------------------------------------------------------------------------
package hvac_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int TEMP_WIDTH_DEF  = 8;

  localparam int SP_W       = 8;
  localparam int BAND_W     = 6;
  localparam int DELAY_W    = 24;
  localparam int CODE_W     = 8;
  localparam int CMD_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_POWER   = 4'd0,
    CMD_MODE    = 4'd1,
    CMD_UP      = 4'd2,
    CMD_DOWN    = 4'd3,
    CMD_BLOWER  = 4'd4,
    CMD_HEATER  = 4'd5,
    CMD_COMP_EN = 4'd6,
    CMD_ERROR   = 4'd7,
    CMD_SAMPLE  = 4'd8,
    CMD_TICK    = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_WAIT_ON  = 2'd1,
    PH_ON       = 2'd2,
    PH_WAIT_OFF = 2'd3
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAN_COND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAN_VENT    = 3'd5;

  typedef struct packed {
    logic [SP_W-1:0]    min_setpoint;
    logic [SP_W-1:0]    max_setpoint;
    logic [BAND_W-1:0]  band;
    logic [DELAY_W-1:0] delay_ticks;
    logic               manual_condenser;
    logic               manual_vent;
  } cfg_t;

  typedef struct packed {
    logic              power_on;
    logic              auto_sel;
    logic [SP_W-1:0]   setpoint;
    logic              blower_user;
    logic              heater_user;
    logic              comp_enable;
    phase_t            comp_phase;
    logic              error_latched;
    logic [CODE_W-1:0] error_code;
  } ctrl_state_t;

  localparam cfg_t CFG_RESET = '{
    min_setpoint:     8'd16,
    max_setpoint:     8'd30,
    band:             6'd2,
    delay_ticks:      24'd180000,
    manual_condenser: 1'b0,
    manual_vent:      1'b0
  };

  localparam ctrl_state_t CTRL_RESET = '{
    power_on:      1'b1,
    auto_sel:      1'b1,
    setpoint:      8'd25,
    blower_user:   1'b1,
    heater_user:   1'b0,
    comp_enable:   1'b1,
    comp_phase:    PH_OFF,
    error_latched: 1'b0,
    error_code:    8'd0
  };

endpackage
`default_nettype wire

// File: hw/rtl/hvac_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvac_cfg_regs
// Configuration register file: limits, band, delay and manual relay drives.
// ----------------------------------------------------------------------------
module hvac_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hvac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hvac_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hvac_pkg::cfg_t                        cfg
);
  import hvac_pkg::*;

  // The user must write only while the block is idle; the block does not enforce it, and a write is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_SP:   cfg.min_setpoint     <= cfg_data[SP_W-1:0];
        CFG_MAX_SP:   cfg.max_setpoint     <= cfg_data[SP_W-1:0];
        CFG_BAND:     cfg.band             <= cfg_data[BAND_W-1:0];
        CFG_DELAY:    cfg.delay_ticks      <= cfg_data[DELAY_W-1:0];
        CFG_MAN_COND: cfg.manual_condenser <= cfg_data[0];
        CFG_MAN_VENT: cfg.manual_vent      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/hvac_ctrl_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvac_ctrl_core
// Controller state and its next-state logic for one command per cycle while step is high.
// ----------------------------------------------------------------------------
module hvac_ctrl_core #(
  parameter int COUNT_WIDTH = hvac_pkg::COUNT_WIDTH_DEF,
  parameter int TEMP_WIDTH  = hvac_pkg::TEMP_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [hvac_pkg::CMD_W-1:0]    command,
  input  wire logic [TEMP_WIDTH-1:0]         temperature,
  input  wire logic [hvac_pkg::CODE_W-1:0]   fault_code,
  input  wire hvac_pkg::cfg_t                cfg,
  output hvac_pkg::ctrl_state_t              st_next
);
  import hvac_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;
  localparam int TW    = (TEMP_WIDTH > SP_W + 1) ? TEMP_WIDTH : SP_W + 1;

  ctrl_state_t            st;
  logic [COUNT_WIDTH-1:0] wait_count;
  logic [COUNT_WIDTH-1:0] wait_count_next;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   wait_done;
  logic [SP_W:0]          hot_limit;
  logic [SP_W-1:0]        cold_limit;
  logic                   too_hot;
  logic                   too_cold;
  cmd_t                   cmd;

  assign cmd        = cmd_t'(command);
  assign count_inc  = wait_count + COUNT_WIDTH'(1);
  assign wait_done  = CMP_W'(count_inc) >= CMP_W'(cfg.delay_ticks);
  assign hot_limit  = (SP_W + 1)'(st.setpoint) + (SP_W + 1)'(cfg.band);
  assign cold_limit = st.setpoint - SP_W'(cfg.band);
  assign too_hot    = TW'(temperature) >= TW'(hot_limit);
  // The lower edge exists only when the band does not reach below zero.
  assign too_cold   = (SP_W'(cfg.band) <= st.setpoint) &&
                      (TW'(temperature) <= TW'(cold_limit));

  always_comb begin
    st_next         = st;
    wait_count_next = wait_count;
    case (cmd)
      CMD_POWER:   st_next.power_on    = !st.power_on;
      CMD_MODE:    st_next.auto_sel    = !st.auto_sel;
      CMD_UP: begin
        if (st.setpoint >= cfg.max_setpoint) begin
          st_next.setpoint = cfg.max_setpoint;
        end else begin
          st_next.setpoint = st.setpoint + SP_W'(1);
        end
      end
      CMD_DOWN: begin
        if (st.setpoint <= cfg.min_setpoint) begin
          st_next.setpoint = cfg.min_setpoint;
        end else begin
          st_next.setpoint = st.setpoint - SP_W'(1);
        end
      end
      CMD_BLOWER:  st_next.blower_user = !st.blower_user;
      CMD_HEATER:  st_next.heater_user = !st.heater_user;
      CMD_COMP_EN: st_next.comp_enable = !st.comp_enable;
      CMD_ERROR: begin
        st_next.error_latched = 1'b1;
        st_next.error_code    = fault_code;
      end
      CMD_SAMPLE: begin
        if (too_hot) begin
          if (st.comp_phase inside {PH_OFF, PH_WAIT_OFF}) begin
            st_next.comp_phase = PH_WAIT_ON;
            wait_count_next    = '0;
          end
        end else if (too_cold) begin
          if (st.comp_phase inside {PH_ON, PH_WAIT_ON}) begin
            st_next.comp_phase = PH_WAIT_OFF;
            wait_count_next    = '0;
          end
        end
      end
      CMD_TICK: begin
        if (st.comp_enable) begin
          if (st.comp_phase inside {PH_WAIT_ON, PH_WAIT_OFF}) begin
            if (wait_done) begin
              st_next.comp_phase = (st.comp_phase == PH_WAIT_ON) ? PH_ON : PH_OFF;
              wait_count_next    = '0;
            end else begin
              wait_count_next = count_inc;
            end
          end
        end else begin
          // A disabled compressor runs the timer in every phase, then is forced off.
          if (wait_done) begin
            st_next.comp_phase = PH_OFF;
            wait_count_next    = '0;
          end else begin
            wait_count_next = count_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= CTRL_RESET;
      wait_count <= '0;
    end else if (step) begin
      st         <= st_next;
      wait_count <= wait_count_next;
    end
  end

  a_no_direct_on: assert property (@(posedge clk) disable iff (rst)
      (st.comp_phase == PH_OFF) |=> (st.comp_phase != PH_ON))
    else $error("compressor went on without a wait");

  a_phase_change_clears: assert property (@(posedge clk) disable iff (rst)
      (step && (st_next.comp_phase != st.comp_phase)) |-> (wait_count_next == '0))
    else $error("phase changed without clearing the wait counter");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
      (step && (command == CMD_TICK) && st.comp_enable &&
       ((st.comp_phase == PH_OFF) || (st.comp_phase == PH_ON)))
      |=> $stable(wait_count))
    else $error("wait counter moved outside a wait phase");

endmodule
`default_nettype wire

// File: hw/rtl/hvac_result_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvac_result_reg
// Relay decode from the updated state and the registered result transaction.
// ----------------------------------------------------------------------------
module hvac_result_reg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire hvac_pkg::ctrl_state_t        st_next,
  input  wire hvac_pkg::cfg_t               cfg,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              condenser_relay,
  output logic                              blower_relay,
  output logic                              vent_relay,
  output logic                              heater_relay,
  output logic                              compressor_relay,
  output logic [hvac_pkg::SP_W-1:0]         setpoint_out,
  output logic                              power_out,
  output logic                              auto_out,
  output logic [1:0]                        compressor_phase,
  output logic                              error_out,
  output logic [hvac_pkg::CODE_W-1:0]       error_code_out
);
  import hvac_pkg::*;

  logic enabled;
  logic comp_on;

  assign enabled = st_next.power_on && !st_next.error_latched;
  assign comp_on = enabled &&
                   ((st_next.comp_phase == PH_ON) || (st_next.comp_phase == PH_WAIT_OFF));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      condenser_relay  <= enabled && (st_next.auto_sel || cfg.manual_condenser);
      blower_relay     <= enabled && (st_next.auto_sel || st_next.blower_user);
      vent_relay       <= enabled && !st_next.auto_sel && cfg.manual_vent;
      heater_relay     <= enabled && !comp_on && st_next.heater_user;
      compressor_relay <= comp_on;
      setpoint_out     <= st_next.setpoint;
      power_out        <= st_next.power_on;
      auto_out         <= st_next.auto_sel;
      compressor_phase <= st_next.comp_phase;
      error_out        <= st_next.error_latched;
      error_code_out   <= st_next.error_code;
    end
  end

  a_heat_cool_exclusive: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> !(heater_relay && compressor_relay))
    else $error("heater and compressor driven together");

  a_error_drops_relays: assert property (@(posedge clk) disable iff (rst)
      (out_valid && error_out) |->
      !(condenser_relay || blower_relay || vent_relay || heater_relay || compressor_relay))
    else $error("relay driven while an error is latched");

endmodule
`default_nettype wire

// File: hw/rtl/hvac_thermostat_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvac_thermostat_controller
// Thermostat with a hysteresis band, a delayed compressor and sticky errors.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    command, temperature, fault_code
//   output    out_valid / out_stall  five relays, set point, status fields
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command is taken every cycle while the result side does not stall;
// the state updates in a single pass between the input and result registers.
// A result is valid after its command passes the input and result registers.
// A stalled result holds the input register, which then stalls the input.
// Synchronous reset loads the controller state and the configuration at once.
// ----------------------------------------------------------------------------
module hvac_thermostat_controller #(
  parameter int COUNT_WIDTH = hvac_pkg::COUNT_WIDTH_DEF,
  parameter int TEMP_WIDTH  = hvac_pkg::TEMP_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [hvac_pkg::CMD_W-1:0]       command,
  input  wire logic [TEMP_WIDTH-1:0]            temperature,
  input  wire logic [hvac_pkg::CODE_W-1:0]      fault_code,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  condenser_relay,
  output logic                                  blower_relay,
  output logic                                  vent_relay,
  output logic                                  heater_relay,
  output logic                                  compressor_relay,
  output logic [hvac_pkg::SP_W-1:0]             setpoint_out,
  output logic                                  power_out,
  output logic                                  auto_out,
  output logic [1:0]                            compressor_phase,
  output logic                                  error_out,
  output logic [hvac_pkg::CODE_W-1:0]           error_code_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hvac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hvac_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hvac_pkg::*;

  cfg_t                    cfg;
  ctrl_state_t             st_next;
  logic                    item_valid;
  logic [CMD_W-1:0]        item_command;
  logic [TEMP_WIDTH-1:0]   item_temperature;
  logic [CODE_W-1:0]       item_fault_code;
  logic                    advance;
  logic                    accept;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_command     <= command;
      item_temperature <= temperature;
      item_fault_code  <= fault_code;
    end
  end

  hvac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hvac_ctrl_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TEMP_WIDTH  (TEMP_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .command     (item_command),
    .temperature (item_temperature),
    .fault_code  (item_fault_code),
    .cfg         (cfg),
    .st_next     (st_next)
  );

  hvac_result_reg u_result (
    .clk              (clk),
    .rst              (rst),
    .load             (advance),
    .st_next          (st_next),
    .cfg              (cfg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .condenser_relay  (condenser_relay),
    .blower_relay     (blower_relay),
    .vent_relay       (vent_relay),
    .heater_relay     (heater_relay),
    .compressor_relay (compressor_relay),
    .setpoint_out     (setpoint_out),
    .power_out        (power_out),
    .auto_out         (auto_out),
    .compressor_phase (compressor_phase),
    .error_out        (error_out),
    .error_code_out   (error_code_out)
  );

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
      (item_valid && !in_stall) |=> out_valid)
    else $error("a command left the input register without a result");

endmodule
`default_nettype wire

// File: tb/sv/hvac_thermostat_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hvac_thermostat_controller_tb
// Self-checking bench for the thermostat controller. Commands are driven
// with random gaps while the result side stalls at random. A state tracker
// predicts every relay and status transaction, and the bench compares it
// field by field against the block. The run steps through several
// set-point, band, delay and manual-relay settings.
// ---------------------------------------------------------------------------
import hvac_pkg::*;

typedef struct packed {
  logic                   condenser;
  logic                   blower;
  logic                   vent;
  logic                   heater;
  logic                   compressor;
  logic [SP_W-1:0]        setpoint;
  logic                   power;
  logic                   auto_sel;
  phase_t                 phase;
  logic                   error;
  logic [CODE_W-1:0]      code;
} relay_status_t;

class relay_scoreboard;
  logic [SP_W-1:0]            min_sp;
  logic [SP_W-1:0]            max_sp;
  logic [BAND_W-1:0]          band;
  logic [DELAY_W-1:0]         delay_ticks;
  logic                       man_condenser;
  logic                       man_vent;
  ctrl_state_t                st;
  logic [COUNT_WIDTH_DEF-1:0] wait_count;
  relay_status_t              expected_status[$];
  int                         mismatches;

  function new();
    min_sp        = CFG_RESET.min_setpoint;
    max_sp        = CFG_RESET.max_setpoint;
    band          = CFG_RESET.band;
    delay_ticks   = CFG_RESET.delay_ticks;
    man_condenser = CFG_RESET.manual_condenser;
    man_vent      = CFG_RESET.manual_vent;
    st            = CTRL_RESET;
    wait_count    = '0;
    mismatches    = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MIN_SP:   min_sp = data[SP_W-1:0];
      CFG_MAX_SP:   max_sp = data[SP_W-1:0];
      CFG_BAND:     band = data[BAND_W-1:0];
      CFG_DELAY:    delay_ticks = data[DELAY_W-1:0];
      CFG_MAN_COND: man_condenser = data[0];
      CFG_MAN_VENT: man_vent = data[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_status.size();
  endfunction

  function void take_sample(logic [TEMP_WIDTH_DEF-1:0] temp);
    int t;
    int sp;
    int b;
    t = int'(temp);
    sp = int'(st.setpoint);
    b = int'(band);
    // The low threshold is compared as a signed sum, so it never wraps.
    if (t >= sp + b) begin
      if (st.comp_phase == PH_OFF || st.comp_phase == PH_WAIT_OFF) begin
        wait_count = '0;
        st.comp_phase = PH_WAIT_ON;
      end
    end else if (t <= sp - b) begin
      if (st.comp_phase == PH_ON || st.comp_phase == PH_WAIT_ON) begin
        wait_count = '0;
        st.comp_phase = PH_WAIT_OFF;
      end
    end
  endfunction

  function void take_tick();
    if (st.comp_enable) begin
      if (st.comp_phase == PH_WAIT_ON || st.comp_phase == PH_WAIT_OFF) begin
        wait_count = wait_count + 1'b1;
        if (wait_count >= delay_ticks) begin
          st.comp_phase = (st.comp_phase == PH_WAIT_ON) ? PH_ON : PH_OFF;
          wait_count = '0;
        end
      end
    end else begin
      // A disabled compressor counts in every phase and is then forced off.
      wait_count = wait_count + 1'b1;
      if (wait_count >= delay_ticks) begin
        st.comp_phase = PH_OFF;
        wait_count = '0;
      end
    end
  endfunction

  function void apply_command(logic [CMD_W-1:0] cmd, logic [TEMP_WIDTH_DEF-1:0] temp,
                              logic [CODE_W-1:0] code);
    relay_status_t r;
    case (cmd)
      CMD_POWER:   st.power_on = ~st.power_on;
      CMD_MODE:    st.auto_sel = ~st.auto_sel;
      CMD_UP:      st.setpoint = (st.setpoint >= max_sp) ? max_sp : st.setpoint + 1'b1;
      CMD_DOWN:    st.setpoint = (st.setpoint <= min_sp) ? min_sp : st.setpoint - 1'b1;
      CMD_BLOWER:  st.blower_user = ~st.blower_user;
      CMD_HEATER:  st.heater_user = ~st.heater_user;
      CMD_COMP_EN: st.comp_enable = ~st.comp_enable;
      CMD_ERROR: begin
        st.error_latched = 1'b1;
        st.error_code = code;
      end
      CMD_SAMPLE:  take_sample(temp);
      CMD_TICK:    take_tick();
      default: ;
    endcase

    r.condenser  = 1'b0;
    r.blower     = 1'b0;
    r.vent       = 1'b0;
    r.heater     = 1'b0;
    r.compressor = 1'b0;
    if (st.power_on && !st.error_latched) begin
      if (st.auto_sel) begin
        r.condenser = 1'b1;
        r.blower    = 1'b1;
      end else begin
        r.condenser = man_condenser;
        r.blower    = st.blower_user;
        r.vent      = man_vent;
      end
      r.compressor = (st.comp_phase == PH_ON || st.comp_phase == PH_WAIT_OFF);
      r.heater     = r.compressor ? 1'b0 : st.heater_user;
    end
    r.setpoint  = st.setpoint;
    r.power     = st.power_on;
    r.auto_sel  = st.auto_sel;
    r.phase     = st.comp_phase;
    r.error     = st.error_latched;
    r.code      = st.error_code;
    expected_status.push_back(r);
  endfunction

  function void compare(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_status(relay_status_t got);
    relay_status_t want;
    if (expected_status.size() == 0) begin
      $error("result transaction arrived with no command outstanding");
      mismatches++;
      return;
    end
    want = expected_status.pop_front();
    compare("condenser_relay", want.condenser, got.condenser);
    compare("blower_relay", want.blower, got.blower);
    compare("vent_relay", want.vent, got.vent);
    compare("heater_relay", want.heater, got.heater);
    compare("compressor_relay", want.compressor, got.compressor);
    compare("setpoint_out", want.setpoint, got.setpoint);
    compare("power_out", want.power, got.power);
    compare("auto_out", want.auto_sel, got.auto_sel);
    compare("compressor_phase", want.phase, got.phase);
    compare("error_out", want.error, got.error);
    compare("error_code_out", want.code, got.code);
  endfunction
endclass

module hvac_thermostat_controller_tb;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            command = '0;
  logic [TEMP_WIDTH_DEF-1:0]   temperature = '0;
  logic [CODE_W-1:0]           fault_code = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        condenser_relay;
  logic                        blower_relay;
  logic                        vent_relay;
  logic                        heater_relay;
  logic                        compressor_relay;
  logic [SP_W-1:0]             setpoint_out;
  logic                        power_out;
  logic                        auto_out;
  logic [1:0]                  compressor_phase;
  logic                        error_out;
  logic [CODE_W-1:0]           error_code_out;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  relay_scoreboard board = new();
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  hvac_thermostat_controller dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    relay_status_t got;
    bit stall_next;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.condenser  = condenser_relay;
        got.blower     = blower_relay;
        got.vent       = vent_relay;
        got.heater     = heater_relay;
        got.compressor = compressor_relay;
        got.setpoint   = setpoint_out;
        got.power      = power_out;
        got.auto_sel   = auto_out;
        got.phase      = phase_t'(compressor_phase);
        got.error      = error_out;
        got.code       = error_code_out;
        board.check_status(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = int'($urandom_range(1, 9)) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value, int width);
    int unsigned keep;
    logic [CFG_DATA_W-1:0] data;
    // Junk above the register width must be ignored by the block.
    keep = (32'd1 << width) - 1;
    data = CFG_DATA_W'((value & keep) | ($urandom & ~keep));
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(idx, data);
  endtask

  task automatic configure(int unsigned min_sp, int unsigned max_sp, int unsigned band_v,
                           int unsigned delay_v, int unsigned man_c, int unsigned man_v);
    write_register(CFG_MIN_SP, min_sp, SP_W);
    write_register(CFG_MAX_SP, max_sp, SP_W);
    write_register(CFG_BAND, band_v, BAND_W);
    write_register(CFG_DELAY, delay_v, DELAY_W);
    write_register(CFG_MAN_COND, man_c, 1);
    write_register(CFG_MAN_VENT, man_v, 1);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [TEMP_WIDTH_DEF-1:0] temp,
                              logic [CODE_W-1:0] code);
    in_valid    <= 1'b1;
    command     <= cmd;
    temperature <= temp;
    fault_code  <= code;
    do @(posedge clk); while (in_stall);
    board.apply_command(cmd, temp, code);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Samples mostly land just around the hysteresis thresholds.
  function automatic logic [TEMP_WIDTH_DEF-1:0] near_setpoint();
    int b;
    int t;
    b = int'(board.band);
    t = int'(board.st.setpoint) + int'($urandom_range(0, 2 * b + 8)) - (b + 4);
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[TEMP_WIDTH_DEF-1:0];
  endfunction

  task automatic run_random(int count, bit allow_error);
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [TEMP_WIDTH_DEF-1:0] temp;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      temp = TEMP_WIDTH_DEF'($urandom_range(0, 255));
      if (pick < 30) begin
        cmd = CMD_TICK;
      end else if (pick < 55) begin
        cmd = CMD_SAMPLE;
        if ($urandom_range(0, 3) != 0) temp = near_setpoint();
      end else if (pick < 65) begin
        cmd = CMD_UP;
      end else if (pick < 75) begin
        cmd = CMD_DOWN;
      end else if (pick < 80) begin
        cmd = CMD_COMP_EN;
      end else if (pick < 84) begin
        cmd = CMD_POWER;
      end else if (pick < 88) begin
        cmd = CMD_MODE;
      end else if (pick < 92) begin
        cmd = CMD_BLOWER;
      end else if (pick < 96) begin
        cmd = CMD_HEATER;
      end else if (pick < 98 || !allow_error) begin
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end else begin
        cmd = CMD_ERROR;
      end
      send_command(cmd, temp, CODE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: auto mode with both manual relays off, long delay.
    send_command(CMD_MODE, 8'd0, 8'd0);
    send_command(CMD_MODE, 8'd0, 8'd0);
    send_command(CMD_SAMPLE, 8'd255, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    send_command(CMD_UNUSED_HI, 8'd255, 8'd255);
    drain();

    configure(24, 26, 3, 2, 1, 1);
    send_command(CMD_UP, 8'd0, 8'd0);
    send_command(CMD_UP, 8'd0, 8'd0);
    send_command(CMD_DOWN, 8'd0, 8'd0);
    send_command(CMD_DOWN, 8'd0, 8'd0);
    send_command(CMD_DOWN, 8'd0, 8'd0);
    send_command(CMD_SAMPLE, 8'd255, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    // Heater request while the compressor runs must keep the heater off.
    send_command(CMD_HEATER, 8'd0, 8'd0);
    send_command(CMD_MODE, 8'd0, 8'd0);
    send_command(CMD_BLOWER, 8'd0, 8'd0);
    send_command(CMD_SAMPLE, 8'd0, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    send_command(CMD_SAMPLE, 8'd255, 8'd0);
    send_command(CMD_COMP_EN, 8'd0, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    send_command(CMD_COMP_EN, 8'd0, 8'd0);
    send_command(CMD_POWER, 8'd0, 8'd0);
    send_command(CMD_POWER, 8'd0, 8'd0);
    send_command(CMD_MODE, 8'd0, 8'd0);
    send_command(CMD_UNUSED_LO, 8'd0, 8'd0);
    drain();

    // Limits in the wrong order, zero band and zero delay.
    configure(255, 0, 0, 0, 0, 1);
    send_command(CMD_UP, 8'd0, 8'd0);
    send_command(CMD_DOWN, 8'd0, 8'd0);
    send_command(CMD_UP, 8'd0, 8'd0);
    send_command(CMD_SAMPLE, 8'd0, 8'd0);
    send_command(CMD_TICK, 8'd0, 8'd0);
    run_random(150, 1'b0);
    drain();

    configure(0, 255, 63, 1, 1, 0);
    run_random(200, 1'b0);
    drain();

    configure(10, 40, 1, 3, 0, 0);
    run_random(150, 1'b0);
    // Long result stall while commands keep coming, to back up the pipeline.
    sender_idle_on = 1'b0;
    hold_left = 60;
    run_random(40, 1'b0);
    sender_idle_on = 1'b1;
    run_random(150, 1'b0);
    drain();

    configure(0, 255, 5, 24'hFFFFFF, 1, 1);
    run_random(100, 1'b0);
    drain();

    configure(20, 28, 2, 4, 1, 1);
    run_random(300, 1'b0);
    drain();

    // Final stretch at full rate; the sticky error comes only in this stretch since
    // only reset clears it.
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    configure(16, 30, 2, 2, 0, 0);
    run_random(200, 1'b0);
    send_command(CMD_ERROR, 8'd0, 8'h00);
    send_command(CMD_ERROR, 8'hFF, 8'hFF);
    run_random(50, 1'b1);

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && board.pending() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d result transactions never arrived", board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/hvac_pkg.sv
hw/rtl/hvac_cfg_regs.sv
hw/rtl/hvac_ctrl_core.sv
hw/rtl/hvac_result_reg.sv
hw/rtl/hvac_thermostat_controller.sv
tb/sv/hvac_thermostat_controller_tb.sv
